>>> rtl/trg_pkg.sv
`timescale 1ns / 1ps

package trg_pkg;

    // Tile size registers are fixed at 13 bits, range 1 to 4096.
    localparam int TILE_W   = 13;
    localparam int TILE_MAX = 4096;

    // Default sizing of the image dimensions and of the layer counts.
    localparam int DIM_BITS_DEF   = 14;
    localparam int LAYER_BITS_DEF = 8;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_TILE_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TILE_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_DEPTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LAYER_COUNT  = 3'd5;

    // States of the sequencer that derives the tile grid after a write.
    typedef enum logic [2:0] {
        CFG_IDLE,
        CFG_LOAD,
        CFG_DIV,
        CFG_MUL,
        CFG_TOT
    } cfg_state_t;

    // Width of the configuration write data: the widest register.
    function automatic int cfg_width(input int dim_bits, input int layer_bits);
        int w;
        begin
            w = TILE_W;
            if (dim_bits + 1 > w)
            begin
                w = dim_bits + 1;
            end
            if (layer_bits + 1 > w)
            begin
                w = layer_bits + 1;
            end
            return w;
        end
    endfunction

endpackage

>>> rtl/trg_cfg.sv
`timescale 1ns / 1ps

module trg_cfg #(
    parameter int DIM_BITS   = trg_pkg::DIM_BITS_DEF,
    parameter int LAYER_BITS = trg_pkg::LAYER_BITS_DEF
) (
    input  logic                                                clk,
    input  logic                                                rst_n,
    input  logic                                                cfg_we,
    input  logic [trg_pkg::CFG_IDX_W-1:0]                       cfg_index,
    input  logic [trg_pkg::cfg_width(DIM_BITS, LAYER_BITS)-1:0] cfg_data,
    output logic                                                busy,
    output logic [trg_pkg::TILE_W-1:0]                          tw,
    output logic [trg_pkg::TILE_W-1:0]                          th,
    output logic [DIM_BITS:0]                                   iw,
    output logic [DIM_BITS:0]                                   ih,
    output logic [DIM_BITS:0]                                   across,
    output logic [2*DIM_BITS:0]                                 per_plane,
    output logic [2*DIM_BITS+2*LAYER_BITS:0]                    total
);
    import trg_pkg::*;

    localparam int IMG_W  = DIM_BITS + 1;
    localparam int LAY_W  = LAYER_BITS + 1;
    localparam int PP_W   = 2 * DIM_BITS + 1;
    localparam int PLN_W  = 2 * LAYER_BITS + 1;
    localparam int TOT_W  = 2 * DIM_BITS + 2 * LAYER_BITS + 1;
    localparam int NUM_W  = ((IMG_W > TILE_W) ? IMG_W : TILE_W) + 1;
    localparam int CNT_W  = $clog2(NUM_W + 1);
    localparam logic [IMG_W-1:0] DIM_MAX = {1'b1, {DIM_BITS{1'b0}}};
    localparam logic [LAY_W-1:0] LAY_MAX = {1'b1, {LAYER_BITS{1'b0}}};

    logic [TILE_W-1:0] tw_raw_reg, th_raw_reg;
    logic [IMG_W-1:0]  iw_raw_reg, ih_raw_reg;
    logic [LAY_W-1:0]  id_raw_reg, il_raw_reg;
    logic [LAY_W-1:0]  id_c, il_c;

    cfg_state_t state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [NUM_W-1:0]  a_num_reg, b_num_reg, a_quo_reg, b_quo_reg;
    logic [TILE_W-1:0] a_rem_reg, b_rem_reg;
    logic [TILE_W:0]   a_sh, b_sh;
    logic              a_ge, b_ge;
    logic [TILE_W-1:0] a_rem_next, b_rem_next;
    logic [NUM_W-1:0]  a_init, b_init;
    logic [2*LAY_W-1:0]  pl_prod;
    logic [2*IMG_W-1:0]  pp_prod;
    logic [PP_W+PLN_W-1:0] tot_prod;
    logic [IMG_W-1:0]  across_reg;
    logic [PP_W-1:0]   per_plane_reg;
    logic [PLN_W-1:0]  planes_reg;
    logic [TOT_W-1:0]  total_reg;

    // Register file; an index beyond the list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tw_raw_reg <= TILE_W'(4);
            th_raw_reg <= TILE_W'(4);
            iw_raw_reg <= IMG_W'(1);
            ih_raw_reg <= IMG_W'(1);
            id_raw_reg <= LAY_W'(1);
            il_raw_reg <= LAY_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TILE_WIDTH:   tw_raw_reg <= cfg_data[TILE_W-1:0];
                REG_TILE_HEIGHT:  th_raw_reg <= cfg_data[TILE_W-1:0];
                REG_IMAGE_WIDTH:  iw_raw_reg <= cfg_data[IMG_W-1:0];
                REG_IMAGE_HEIGHT: ih_raw_reg <= cfg_data[IMG_W-1:0];
                REG_IMAGE_DEPTH:  id_raw_reg <= cfg_data[LAY_W-1:0];
                REG_LAYER_COUNT:  il_raw_reg <= cfg_data[LAY_W-1:0];
                default:          ;
            endcase
        end
    end

    // Zero is taken as one and values above range as the bound.
    always_comb
    begin
        tw = (tw_raw_reg == '0) ? TILE_W'(1) :
             (tw_raw_reg > TILE_W'(TILE_MAX)) ? TILE_W'(TILE_MAX) : tw_raw_reg;
        th = (th_raw_reg == '0) ? TILE_W'(1) :
             (th_raw_reg > TILE_W'(TILE_MAX)) ? TILE_W'(TILE_MAX) : th_raw_reg;
        iw = (iw_raw_reg == '0) ? IMG_W'(1) :
             (iw_raw_reg > DIM_MAX) ? DIM_MAX : iw_raw_reg;
        ih = (ih_raw_reg == '0) ? IMG_W'(1) :
             (ih_raw_reg > DIM_MAX) ? DIM_MAX : ih_raw_reg;
        id_c = (id_raw_reg == '0) ? LAY_W'(1) :
               (id_raw_reg > LAY_MAX) ? LAY_MAX : id_raw_reg;
        il_c = (il_raw_reg == '0) ? LAY_W'(1) :
               (il_raw_reg > LAY_MAX) ? LAY_MAX : il_raw_reg;
    end

    // One bit of each ceiling division per cycle, plus the grid products.
    always_comb
    begin
        a_init = NUM_W'(iw) + NUM_W'(tw) - NUM_W'(1);
        b_init = NUM_W'(ih) + NUM_W'(th) - NUM_W'(1);
        a_sh = {a_rem_reg, a_num_reg[NUM_W-1]};
        b_sh = {b_rem_reg, b_num_reg[NUM_W-1]};
        a_ge = a_sh >= (TILE_W + 1)'(tw);
        b_ge = b_sh >= (TILE_W + 1)'(th);
        a_rem_next = a_ge ? TILE_W'(a_sh - (TILE_W + 1)'(tw)) : a_sh[TILE_W-1:0];
        b_rem_next = b_ge ? TILE_W'(b_sh - (TILE_W + 1)'(th)) : b_sh[TILE_W-1:0];
        pl_prod  = id_c * il_c;
        pp_prod  = a_quo_reg[IMG_W-1:0] * b_quo_reg[IMG_W-1:0];
        tot_prod = per_plane_reg * planes_reg;
    end

    // Sequencer state register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CFG_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Any write restarts the derivation of the grid.
    always_comb
    begin
        state_next = state_reg;
        priority if (cfg_we)
        begin
            state_next = CFG_LOAD;
        end
        else
        begin
            unique case (state_reg)
                CFG_IDLE: state_next = CFG_IDLE;
                CFG_LOAD: state_next = CFG_DIV;
                CFG_DIV:  state_next = (cnt_reg == CNT_W'(NUM_W - 1)) ? CFG_MUL : CFG_DIV;
                CFG_MUL:  state_next = CFG_TOT;
                CFG_TOT:  state_next = CFG_IDLE;
                default:  state_next = CFG_IDLE;
            endcase
        end
    end

    // Division working registers.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            CFG_LOAD:
            begin
                a_num_reg <= a_init;
                b_num_reg <= b_init;
                a_rem_reg <= '0;
                b_rem_reg <= '0;
                a_quo_reg <= '0;
                b_quo_reg <= '0;
                cnt_reg   <= '0;
            end
            CFG_DIV:
            begin
                a_num_reg <= a_num_reg << 1;
                b_num_reg <= b_num_reg << 1;
                a_rem_reg <= a_rem_next;
                b_rem_reg <= b_rem_next;
                a_quo_reg <= {a_quo_reg[NUM_W-2:0], a_ge};
                b_quo_reg <= {b_quo_reg[NUM_W-2:0], b_ge};
                cnt_reg   <= cnt_reg + CNT_W'(1);
            end
            default: ;
        endcase
    end

    // Derived grid values, valid for the reset configuration at once.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            across_reg    <= IMG_W'(1);
            per_plane_reg <= PP_W'(1);
            planes_reg    <= PLN_W'(1);
            total_reg     <= TOT_W'(1);
        end
        else if (state_reg == CFG_MUL)
        begin
            across_reg    <= a_quo_reg[IMG_W-1:0];
            per_plane_reg <= pp_prod[PP_W-1:0];
            planes_reg    <= pl_prod[PLN_W-1:0];
        end
        else if (state_reg == CFG_TOT)
        begin
            total_reg <= tot_prod[TOT_W-1:0];
        end
    end

    assign busy      = (state_reg != CFG_IDLE);
    assign across    = across_reg;
    assign per_plane = per_plane_reg;
    assign total     = total_reg;

endmodule

>>> rtl/trg_div_cell.sv
`timescale 1ns / 1ps

module trg_div_cell #(
    parameter int REM_W  = 44,
    parameter int DIV_W  = 29,
    parameter int Q_W    = 16,
    parameter int BIT    = 0,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [REM_W-1:0]  in_rem,
    input  logic [Q_W-1:0]    in_quo,
    input  logic [SIDE_W-1:0] in_side,
    input  logic [DIV_W-1:0]  divisor,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [REM_W-1:0]  out_rem,
    output logic [Q_W-1:0]    out_quo,
    output logic [SIDE_W-1:0] out_side
);

    localparam int CW = (REM_W > DIV_W + Q_W) ? REM_W : DIV_W + Q_W;

    logic              valid_reg;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [Q_W-1:0]    quo_reg, quo_next;
    logic [SIDE_W-1:0] side_reg;
    logic [CW-1:0]     rem_x, dsh, diff;
    logic              hit;

    // One restoring step: try the divisor at this cell's bit weight.
    always_comb
    begin
        rem_x    = CW'(in_rem);
        dsh      = CW'(divisor) << BIT;
        diff     = rem_x - dsh;
        hit      = (rem_x >= dsh);
        rem_next = hit ? diff[REM_W-1:0] : in_rem;
        quo_next = in_quo | (Q_W'(hit) << BIT);
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_quo   = quo_reg;
    assign out_side  = side_reg;

endmodule

>>> rtl/trg_div_chain.sv
`timescale 1ns / 1ps

module trg_div_chain #(
    parameter int REM_W  = 44,
    parameter int DIV_W  = 29,
    parameter int Q_W    = 16,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [REM_W-1:0]  in_rem,
    input  logic [SIDE_W-1:0] in_side,
    input  logic [DIV_W-1:0]  divisor,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [REM_W-1:0]  out_rem,
    output logic [Q_W-1:0]    out_quo,
    output logic [SIDE_W-1:0] out_side
);

    logic              v_w    [0:Q_W];
    logic              rdy_w  [0:Q_W];
    logic [REM_W-1:0]  rem_w  [0:Q_W];
    logic [Q_W-1:0]    quo_w  [0:Q_W];
    logic [SIDE_W-1:0] side_w [0:Q_W];

    assign v_w[0]    = in_valid;
    assign in_ready  = rdy_w[0];
    assign rem_w[0]  = in_rem;
    assign quo_w[0]  = '0;
    assign side_w[0] = in_side;

    // Cell k settles quotient bit Q_W-1-k, most significant first.
    for (genvar k = 0; k < Q_W; k++)
    begin : g_cell
        trg_div_cell #(
            .REM_W  (REM_W),
            .DIV_W  (DIV_W),
            .Q_W    (Q_W),
            .BIT    (Q_W - 1 - k),
            .SIDE_W (SIDE_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (v_w[k]),
            .in_ready  (rdy_w[k]),
            .in_rem    (rem_w[k]),
            .in_quo    (quo_w[k]),
            .in_side   (side_w[k]),
            .divisor   (divisor),
            .out_valid (v_w[k+1]),
            .out_ready (rdy_w[k+1]),
            .out_rem   (rem_w[k+1]),
            .out_quo   (quo_w[k+1]),
            .out_side  (side_w[k+1])
        );
    end

    assign rdy_w[Q_W] = out_ready;
    assign out_valid  = v_w[Q_W];
    assign out_rem    = rem_w[Q_W];
    assign out_quo    = quo_w[Q_W];
    assign out_side   = side_w[Q_W];

endmodule

>>> rtl/tile_rect_generator_core.sv
`timescale 1ns / 1ps

// Tile rectangle generator.
// Input channel (in_valid/in_ready) carries a linear tile index; the output
// channel (out_valid/out_ready) returns one item per index: plane, origin,
// the tile size clipped at the right and bottom image edges, the total tile
// count and an out_of_range flag. Out-of-range items return zero geometry.
// The index is split by two rows of divider cells, one quotient bit per
// cell: 2*LAYER_BITS cells for the plane, DIM_BITS cells for the tile row,
// then one multiply stage and one clip/output stage. One item is accepted
// per cycle while the sequencer is idle and no stall has filled the cells.
// A configuration write starts a sequencer that derives tiles across, tiles
// per plane and the total count; in_ready stays low after the last write
// until the sequencer is idle again.
// Reset loads the register defaults, whose derived values are ready at once.
// When the receiver stalls, items collect in the cell row; every cell holding
// a bubble still takes a new item, so input stops only when the row is full.

module tile_rect_generator_core #(
    parameter int DIM_BITS   = trg_pkg::DIM_BITS_DEF,
    parameter int LAYER_BITS = trg_pkg::LAYER_BITS_DEF
) (
    input  logic                                                clk,
    input  logic                                                rst_n,
    input  logic                                                cfg_we,
    input  logic [trg_pkg::CFG_IDX_W-1:0]                       cfg_index,
    input  logic [trg_pkg::cfg_width(DIM_BITS, LAYER_BITS)-1:0] cfg_data,
    input  logic                                                in_valid,
    output logic                                                in_ready,
    input  logic [2*DIM_BITS+2*LAYER_BITS-1:0]                  tile_number,
    output logic                                                out_valid,
    input  logic                                                out_ready,
    output logic [2*LAYER_BITS-1:0]                             plane,
    output logic [DIM_BITS-1:0]                                 origin_x,
    output logic [DIM_BITS-1:0]                                 origin_y,
    output logic [trg_pkg::TILE_W-1:0]                          rect_width,
    output logic [trg_pkg::TILE_W-1:0]                          rect_height,
    output logic [2*DIM_BITS+2*LAYER_BITS:0]                    total_tiles,
    output logic                                                out_of_range
);
    import trg_pkg::*;

    localparam int IDX_W = 2 * DIM_BITS + 2 * LAYER_BITS;
    localparam int TOT_W = IDX_W + 1;
    localparam int PL_W  = 2 * LAYER_BITS;
    localparam int IMG_W = DIM_BITS + 1;
    localparam int PP_W  = 2 * DIM_BITS + 1;
    localparam int SW    = ((DIM_BITS > TILE_W) ? DIM_BITS : TILE_W) + 1;

    logic              busy;
    logic [TILE_W-1:0] tw, th;
    logic [IMG_W-1:0]  iw, ih, across;
    logic [PP_W-1:0]   per_plane;
    logic [TOT_W-1:0]  total;

    logic             a_in_ready, a_valid, a_ready, oor_in;
    logic [IDX_W-1:0] a_rem;
    logic [PL_W-1:0]  a_quo;
    logic             a_side;

    logic                b_valid, b_ready;
    logic [PP_W-1:0]     b_rem;
    logic [DIM_BITS-1:0] b_quo;
    logic [PL_W:0]       b_side;

    logic                       m_valid_reg, m_ready;
    logic [DIM_BITS-1:0]        m_ox_reg, m_oy_reg;
    logic [PL_W-1:0]            m_plane_reg;
    logic                       m_oor_reg;
    logic [DIM_BITS+TILE_W-1:0] ox_prod, oy_prod;

    logic                f_ready;
    logic                o_valid_reg;
    logic [PL_W-1:0]     o_plane_reg;
    logic [DIM_BITS-1:0] o_ox_reg, o_oy_reg;
    logic [TILE_W-1:0]   o_w_reg, o_h_reg;
    logic                o_oor_reg;
    logic [SW-1:0]       x_end, y_end, iw_x, ih_x;
    logic [TILE_W-1:0]   w_clip, h_clip;

    trg_cfg #(
        .DIM_BITS   (DIM_BITS),
        .LAYER_BITS (LAYER_BITS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .busy      (busy),
        .tw        (tw),
        .th        (th),
        .iw        (iw),
        .ih        (ih),
        .across    (across),
        .per_plane (per_plane),
        .total     (total)
    );

    // Range check at entry; the flag travels with the item.
    assign oor_in   = ({1'b0, tile_number} >= total);
    assign in_ready = a_in_ready && !busy;

    // Plane = index / tiles per plane, remainder = index within the plane.
    trg_div_chain #(
        .REM_W  (IDX_W),
        .DIV_W  (PP_W),
        .Q_W    (PL_W),
        .SIDE_W (1)
    ) u_plane_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid && !busy),
        .in_ready  (a_in_ready),
        .in_rem    (tile_number),
        .in_side   (oor_in),
        .divisor   (per_plane),
        .out_valid (a_valid),
        .out_ready (a_ready),
        .out_rem   (a_rem),
        .out_quo   (a_quo),
        .out_side  (a_side)
    );

    // Row = within / tiles across, column = the remainder.
    trg_div_chain #(
        .REM_W  (PP_W),
        .DIV_W  (IMG_W),
        .Q_W    (DIM_BITS),
        .SIDE_W (PL_W + 1)
    ) u_row_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (a_valid),
        .in_ready  (a_ready),
        .in_rem    (a_rem[PP_W-1:0]),
        .in_side   ({a_side, a_quo}),
        .divisor   (across),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_rem   (b_rem),
        .out_quo   (b_quo),
        .out_side  (b_side)
    );

    // Multiply stage: pixel origin of the tile.
    assign ox_prod = b_rem[DIM_BITS-1:0] * tw;
    assign oy_prod = b_quo * th;
    assign m_ready = !m_valid_reg || f_ready;
    assign b_ready = m_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (m_ready)
        begin
            m_valid_reg <= b_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_valid && m_ready)
        begin
            m_ox_reg    <= ox_prod[DIM_BITS-1:0];
            m_oy_reg    <= oy_prod[DIM_BITS-1:0];
            m_plane_reg <= b_side[PL_W-1:0];
            m_oor_reg   <= b_side[PL_W];
        end
    end

    // Clip stage: shorten tiles that reach past the image edge.
    always_comb
    begin
        iw_x   = SW'(iw);
        ih_x   = SW'(ih);
        x_end  = SW'(m_ox_reg) + SW'(tw);
        y_end  = SW'(m_oy_reg) + SW'(th);
        w_clip = (x_end > iw_x) ? TILE_W'(iw_x - SW'(m_ox_reg)) : tw;
        h_clip = (y_end > ih_x) ? TILE_W'(ih_x - SW'(m_oy_reg)) : th;
    end

    assign f_ready = !o_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
        end
        else if (f_ready)
        begin
            o_valid_reg <= m_valid_reg;
        end
    end

    // Output register; out-of-range items carry zero geometry.
    always_ff @(posedge clk)
    begin
        if (m_valid_reg && f_ready)
        begin
            o_oor_reg   <= m_oor_reg;
            o_plane_reg <= m_oor_reg ? '0 : m_plane_reg;
            o_ox_reg    <= m_oor_reg ? '0 : m_ox_reg;
            o_oy_reg    <= m_oor_reg ? '0 : m_oy_reg;
            o_w_reg     <= m_oor_reg ? '0 : w_clip;
            o_h_reg     <= m_oor_reg ? '0 : h_clip;
        end
    end

    assign out_valid    = o_valid_reg;
    assign plane        = o_plane_reg;
    assign origin_x     = o_ox_reg;
    assign origin_y     = o_oy_reg;
    assign rect_width   = o_w_reg;
    assign rect_height  = o_h_reg;
    assign total_tiles  = total;
    assign out_of_range = o_oor_reg;

endmodule

>>> rtl/trg_checker.sv
`timescale 1ns / 1ps

module trg_checker #(
    parameter int DIM_BITS   = trg_pkg::DIM_BITS_DEF,
    parameter int LAYER_BITS = trg_pkg::LAYER_BITS_DEF
) (
    input  logic                                                clk,
    input  logic                                                rst_n,
    input  logic                                                cfg_we,
    input  logic                                                in_ready,
    input  logic                                                out_valid,
    input  logic                                                out_ready,
    input  logic [2*LAYER_BITS-1:0]                             plane,
    input  logic [DIM_BITS-1:0]                                 origin_x,
    input  logic [DIM_BITS-1:0]                                 origin_y,
    input  logic [trg_pkg::TILE_W-1:0]                          rect_width,
    input  logic [trg_pkg::TILE_W-1:0]                          rect_height,
    input  logic                                                out_of_range
);

    // A stalled result item holds its geometry.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(plane) && $stable(origin_x)
            && $stable(origin_y) && $stable(rect_width) && $stable(rect_height)
            && $stable(out_of_range))
        else $error("stalled result item changed");

    // Out-of-range items carry zero geometry.
    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_of_range |-> plane == '0 && origin_x == '0 && origin_y == '0
            && rect_width == '0 && rect_height == '0)
        else $error("out-of-range item with nonzero geometry");

    // A valid tile is never empty.
    a_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_of_range |-> rect_width != '0 && rect_height != '0)
        else $error("empty tile rectangle");

    // The grid is being rederived right after a write; no item is taken.
    a_cfg_block: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> !in_ready)
        else $error("item accepted during grid update");

endmodule

bind tile_rect_generator_core trg_checker #(
    .DIM_BITS   (DIM_BITS),
    .LAYER_BITS (LAYER_BITS)
) u_trg_checker (.*);
